FILE: rtl/pfr_pkg.sv
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int PAGE_W   = 52;
  localparam int ADDR_W   = 64;
  localparam int MAP_W    = 64;
  localparam int AGE_W    = 16;
  localparam int MODE_W   = 2;
  localparam int PAGE_LSB = 12;
  localparam int BLK_LSB  = 6;
  localparam int BLK_W    = 6;

  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REUSE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GATHER = 2'd2;

  typedef struct packed {
    logic capture;
    logic rec_hit;
    logic rec_free;
    logic rec_victim;
    logic mark;
    logic scan_start;
    logic scan_step;
    logic gather_init;
    logic load_entry;
    logic load_empty;
  } pfr_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hit;
    logic              free_avail;
    logic              empty;
    logic              scan_last;
    logic              out_last;
  } pfr_sts_t;

endpackage

FILE: rtl/pfr_ctrl.sv
`timescale 1ns / 1ps

module pfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pfr_pkg::pfr_sts_t sts_i,
  output pfr_pkg::pfr_cmd_t cmd_o
);
  import pfr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOOKUP  = 3'd1;
  localparam logic [2:0] ST_VSCAN   = 3'd2;
  localparam logic [2:0] ST_VCOMMIT = 3'd3;
  localparam logic [2:0] ST_GSCAN   = 3'd4;
  localparam logic [2:0] ST_GLOAD   = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        case (sts_i.mode)
          MODE_RECORD: begin
            if (sts_i.hit) begin
              cmd_o.rec_hit = 1'b1;
              state_d       = ST_IDLE;
            end else if (sts_i.free_avail) begin
              cmd_o.rec_free = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_VSCAN;
            end
          end
          MODE_REUSE: begin
            cmd_o.mark = 1'b1;
            state_d    = ST_IDLE;
          end
          MODE_GATHER: begin
            if (sts_i.empty) begin
              cmd_o.load_empty = 1'b1;
              state_d          = ST_OUT;
            end else begin
              cmd_o.gather_init = 1'b1;
              cmd_o.scan_start  = 1'b1;
              state_d           = ST_GSCAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_VSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_VCOMMIT;
        end
      end
      ST_VCOMMIT: begin
        cmd_o.rec_victim = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_GSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_GLOAD;
        end
      end
      ST_GLOAD: begin
        cmd_o.load_entry = 1'b1;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_GSCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/pfr_datapath.sv
`timescale 1ns / 1ps

module pfr_datapath #(
  parameter int TABLE_ENTRIES = pfr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pfr_pkg::MODE_W-1:0]  mode_i,
  input  logic [pfr_pkg::ADDR_W-1:0]  address_i,
  input  logic                        cfg_valid_i,
  input  logic                        ignore_reuse_i,
  input  pfr_pkg::pfr_cmd_t           cmd_i,
  output pfr_pkg::pfr_sts_t           sts_o,
  output logic [pfr_pkg::PAGE_W-1:0]  page_number_o,
  output logic [pfr_pkg::MAP_W-1:0]   block_mask_o,
  output logic                        entry_valid_o,
  output logic                        last_o
);
  import pfr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [MODE_W-1:0] mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic              ign_q;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] reuse_q, reuse_d;
  logic [PAGE_W-1:0]        page_q [TABLE_ENTRIES];
  logic [MAP_W-1:0]         map_q  [TABLE_ENTRIES];
  logic [MAP_W-1:0]         map_d  [TABLE_ENTRIES];
  logic [AGE_W-1:0]         age_q  [TABLE_ENTRIES];
  logic [AGE_W-1:0]         age_d  [TABLE_ENTRIES];

  logic [CNT_W-1:0] cnt_q, emitted_q, emitted_nx;
  logic [IDX_W-1:0] scan_idx_q;
  logic [AGE_W-1:0] best_age_q, prev_age_q;
  logic [IDX_W-1:0] best_idx_q, prev_idx_q;
  logic             found_q, has_prev_q;

  logic [PAGE_W-1:0] page_q_out;
  logic [MAP_W-1:0]  mask_q_out;
  logic              ev_q, last_q;

  logic [PAGE_W-1:0] cur_page;
  logic [MAP_W-1:0]  cur_bit;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx, free_idx, touch_idx;
  logic              free_avail, halve, do_rec, do_alloc;
  logic [AGE_W-1:0]  cur_age, lane_age;
  logic              take;

  assign cur_page = addr_q[ADDR_W-1:PAGE_LSB];
  assign cur_bit  = MAP_W'(1) << addr_q[BLK_LSB +: BLK_W];

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_avail = 1'b0;
    free_idx   = '0;
    halve      = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == cur_page)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_avail = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (&age_q[i]) begin
        halve = 1'b1;
      end
    end
  end

  assign do_alloc = cmd_i.rec_free | cmd_i.rec_victim;
  assign do_rec   = cmd_i.rec_hit | do_alloc;

  always_comb begin
    if (cmd_i.rec_hit) begin
      touch_idx = hit_idx;
    end else if (cmd_i.rec_free) begin
      touch_idx = free_idx;
    end else begin
      touch_idx = best_idx_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    reuse_d = reuse_q;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      map_d[i] = map_q[i];
      age_d[i] = age_q[i];
      lane_age = '0;
      if (do_alloc && (touch_idx == IDX_W'(i))) begin
        valid_d[i] = 1'b1;
        reuse_d[i] = 1'b0;
        map_d[i]   = cur_bit;
      end else if (cmd_i.rec_hit && (touch_idx == IDX_W'(i))) begin
        map_d[i] = map_q[i] | cur_bit;
      end
      if (cmd_i.mark && valid_q[i] && (page_q[i] == cur_page)) begin
        reuse_d[i] = 1'b1;
      end
      if (do_rec) begin
        lane_age = halve ? (age_q[i] >> 1) : age_q[i];
        if (touch_idx == IDX_W'(i)) begin
          lane_age = '0;
        end
        if (valid_d[i]) begin
          lane_age = lane_age + AGE_W'(1);
        end
        age_d[i] = lane_age;
      end
    end
  end

  assign cur_age = age_q[scan_idx_q];

  always_comb begin
    if (mode_q == MODE_GATHER) begin
      take = valid_q[scan_idx_q]
           && (!has_prev_q || ({cur_age, scan_idx_q} > {prev_age_q, prev_idx_q}))
           && (!found_q || ({cur_age, scan_idx_q} < {best_age_q, best_idx_q}));
    end else begin
      take = valid_q[scan_idx_q] && (cur_age > best_age_q);
    end
  end

  assign emitted_nx = emitted_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      reuse_q    <= '0;
      ign_q      <= 1'b0;
      cnt_q      <= '0;
      emitted_q  <= '0;
      scan_idx_q <= '0;
      found_q    <= 1'b0;
      has_prev_q <= 1'b0;
      mode_q     <= MODE_RECORD;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        map_q[i] <= '0;
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      reuse_q <= reuse_d;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        map_q[i] <= map_d[i];
        age_q[i] <= age_d[i];
      end
      if (cfg_valid_i) begin
        ign_q <= ignore_reuse_i;
      end
      if (cmd_i.capture) begin
        mode_q <= mode_i;
      end
      if (cmd_i.rec_free) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.gather_init) begin
        emitted_q  <= '0;
        has_prev_q <= 1'b0;
      end else if (cmd_i.load_entry) begin
        emitted_q  <= emitted_nx;
        has_prev_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        if (take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= address_i;
    end
    if (do_alloc) begin
      page_q[touch_idx] <= cur_page;
    end
    if (cmd_i.scan_start) begin
      best_age_q <= '0;
      best_idx_q <= '0;
    end else if (cmd_i.scan_step && take) begin
      best_age_q <= cur_age;
      best_idx_q <= scan_idx_q;
    end
    if (cmd_i.load_entry) begin
      prev_age_q <= best_age_q;
      prev_idx_q <= best_idx_q;
      page_q_out <= page_q[best_idx_q];
      mask_q_out <= (ign_q || reuse_q[best_idx_q]) ? map_q[best_idx_q] : '0;
      ev_q       <= 1'b1;
      last_q     <= (emitted_nx == cnt_q);
    end else if (cmd_i.load_empty) begin
      page_q_out <= '0;
      mask_q_out <= '0;
      ev_q       <= 1'b0;
      last_q     <= 1'b1;
    end
  end

  assign sts_o.mode       = mode_q;
  assign sts_o.hit        = hit;
  assign sts_o.free_avail = free_avail;
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.scan_last  = (scan_idx_q == LAST_IDX);
  assign sts_o.out_last   = last_q;

  assign page_number_o = page_q_out;
  assign block_mask_o  = mask_q_out;
  assign entry_valid_o = ev_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/page_footprint_recorder_unit.sv
`timescale 1ns / 1ps

// Records which 64-byte blocks of each 4 KiB page are touched, in a fully
// associative table of TABLE_ENTRIES entries with age-based replacement.
// The input channel takes one word per item: mode 0 records an access at
// address_i, mode 1 marks the page of address_i as reused, mode 2 gathers
// the table and mode 3 is dropped. Only gathers produce output words, one
// per valid entry, youngest first, with last_o on the final one; an empty
// table gives a single word with entry_valid_o low and last_o high.
// A record that hits, a record into a free entry, a reuse mark and a dropped
// item go from acceptance through the lookup state back to in_ready_o. A
// record that must evict first finds the oldest entry by a scan of one entry
// per cycle and then commits it. A gather scans the whole table for every
// output word, and an empty gather answers directly from the lookup state.
// The block works on one item at a time, and a stalled output word simply
// holds until out_ready_i rises; in_ready_o returns the cycle after the final
// word is taken. The always-ready configuration channel sets ignore_reuse;
// the user writes it only while the block is idle; the block does not check.
// Reset clears the table, the ages and ignore_reuse.
module page_footprint_recorder_unit #(
  parameter int TABLE_ENTRIES = pfr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfr_pkg::MODE_W-1:0]  mode_i,
  input  logic [pfr_pkg::ADDR_W-1:0]  address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfr_pkg::PAGE_W-1:0]  page_number_o,
  output logic [pfr_pkg::MAP_W-1:0]   block_mask_o,
  output logic                        entry_valid_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        ignore_reuse_i
);
  import pfr_pkg::*;

  pfr_cmd_t cmd;
  pfr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfr_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .cfg_valid_i    (cfg_valid_i),
    .ignore_reuse_i (ignore_reuse_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .page_number_o  (page_number_o),
    .block_mask_o   (block_mask_o),
    .entry_valid_o  (entry_valid_o),
    .last_o         (last_o)
  );

endmodule

FILE: rtl/pfr_checker.sv
`timescale 1ns / 1ps

module pfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [pfr_pkg::PAGE_W-1:0]  page_number_o,
  input logic [pfr_pkg::MAP_W-1:0]   block_mask_o,
  input logic                        entry_valid_o,
  input logic                        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(page_number_o)
      && $stable(block_mask_o) && $stable(last_o))
    else $error("Output word changed while stalled.");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while an output word is pending.");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_o)
    else $error("Invalid entry word is not the final word.");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("Output word appeared right after acceptance.");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o)
    else $error("Output continued after the final word.");

endmodule

bind page_footprint_recorder_unit pfr_checker u_pfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .page_number_o (page_number_o),
  .block_mask_o  (block_mask_o),
  .entry_valid_o (entry_valid_o),
  .last_o        (last_o)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [pfr_pkg::PAGE_W-1:0] page_no;
  logic [pfr_pkg::MAP_W-1:0]  mask;
  logic                       valid;
  logic                       last;
} footprint_word_t;

class footprint_model;
  localparam int N = pfr_pkg::TABLE_ENTRIES_DEF;

  bit                         ent_valid [N];
  bit                         ent_reuse [N];
  logic [pfr_pkg::PAGE_W-1:0] ent_page  [N];
  logic [pfr_pkg::MAP_W-1:0]  ent_map   [N];
  logic [pfr_pkg::AGE_W-1:0]  ent_age   [N];
  bit                         ignore_reuse;
  footprint_word_t            pending_words [$];
  int                         mismatches;

  function new();
    foreach (ent_valid[i]) begin
      ent_valid[i] = 1'b0;
      ent_reuse[i] = 1'b0;
      ent_page[i]  = '0;
      ent_map[i]   = '0;
      ent_age[i]   = '0;
    end
    ignore_reuse = 1'b0;
    mismatches   = 0;
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t: %s mismatch, got %h, wanted %h", $time, what, got, want);
  endtask

  function int outstanding();
    return pending_words.size();
  endfunction

  function void refresh_ages(int touched);
    bit halve;
    halve = 1'b0;
    foreach (ent_age[i]) begin
      if (ent_age[i] == '1) begin
        halve = 1'b1;
      end
    end
    if (halve) begin
      foreach (ent_age[i]) begin
        ent_age[i] = ent_age[i] >> 1;
      end
    end
    ent_age[touched] = '0;
    foreach (ent_age[i]) begin
      if (ent_valid[i]) begin
        ent_age[i] = ent_age[i] + 1'b1;
      end
    end
  endfunction

  function void record(logic [pfr_pkg::ADDR_W-1:0] addr);
    logic [pfr_pkg::PAGE_W-1:0] pg;
    logic [pfr_pkg::MAP_W-1:0]  block_bit;
    logic [pfr_pkg::AGE_W-1:0]  oldest;
    int                         victim;
    pg        = addr[pfr_pkg::ADDR_W-1:pfr_pkg::PAGE_LSB];
    block_bit = 64'd1 << addr[pfr_pkg::BLK_LSB +: pfr_pkg::BLK_W];
    oldest    = '0;
    victim    = -1;
    foreach (ent_valid[i]) begin
      if (victim < 0 && ent_valid[i] && ent_page[i] == pg) begin
        victim = i;
      end
    end
    if (victim >= 0) begin
      ent_map[victim] |= block_bit;
      refresh_ages(victim);
      return;
    end
    foreach (ent_valid[i]) begin
      if (victim < 0 && !ent_valid[i]) begin
        victim = i;
      end
    end
    if (victim < 0) begin
      victim = 0;
      foreach (ent_valid[i]) begin
        if (ent_valid[i] && ent_age[i] > oldest) begin
          victim = i;
          oldest = ent_age[i];
        end
      end
    end
    ent_valid[victim] = 1'b1;
    ent_page[victim]  = pg;
    ent_reuse[victim] = 1'b0;
    ent_map[victim]   = block_bit;
    refresh_ages(victim);
  endfunction

  function void mark(logic [pfr_pkg::ADDR_W-1:0] addr);
    foreach (ent_valid[i]) begin
      if (ent_valid[i] && ent_page[i] == addr[pfr_pkg::ADDR_W-1:pfr_pkg::PAGE_LSB]) begin
        ent_reuse[i] = 1'b1;
      end
    end
  endfunction

  function void gather();
    bit              taken [N];
    int              count;
    int              best;
    footprint_word_t w;
    count = 0;
    foreach (ent_valid[i]) begin
      count += ent_valid[i];
    end
    if (count == 0) begin
      w             = '0;
      w.last        = 1'b1;
      pending_words = {pending_words, w};
      return;
    end
    for (int k = 0; k < count; k++) begin
      best = -1;
      foreach (ent_valid[i]) begin
        if (ent_valid[i] && !taken[i] && (best < 0 || ent_age[i] < ent_age[best])) begin
          best = i;
        end
      end
      taken[best]   = 1'b1;
      w.page_no     = ent_page[best];
      w.mask        = (ignore_reuse || ent_reuse[best]) ? ent_map[best] : '0;
      w.valid       = 1'b1;
      w.last        = (k == count - 1);
      pending_words = {pending_words, w};
    end
  endfunction

  function void note_item(logic [pfr_pkg::MODE_W-1:0] mode,
                          logic [pfr_pkg::ADDR_W-1:0] addr);
    case (mode)
      pfr_pkg::MODE_RECORD: begin
        record(addr);
      end
      pfr_pkg::MODE_REUSE: begin
        mark(addr);
      end
      pfr_pkg::MODE_GATHER: begin
        gather();
      end
      default: begin
      end
    endcase
  endfunction

  task check_word(logic [pfr_pkg::PAGE_W-1:0] pg, logic [pfr_pkg::MAP_W-1:0] mask,
                  logic valid, logic last);
    footprint_word_t w;
    if (pending_words.size() == 0) begin
      report("unexpected word, page_number", 64'(pg), '0);
      return;
    end
    w = pending_words.pop_front();
    if (pg !== w.page_no) begin
      report("page_number", 64'(pg), 64'(w.page_no));
    end
    if (mask !== w.mask) begin
      report("block_mask", mask, w.mask);
    end
    if (valid !== w.valid) begin
      report("entry_valid", 64'(valid), 64'(w.valid));
    end
    if (last !== w.last) begin
      report("last", 64'(last), 64'(w.last));
    end
  endtask
endclass

module tb;
  import pfr_pkg::*;

  localparam int ENTRIES       = TABLE_ENTRIES_DEF;
  localparam int POOL          = 24;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int HOT_HITS      = 8;
  localparam int PHASE_ITEMS   = 28;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [MODE_W-1:0] mode_i;
  logic [ADDR_W-1:0] address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PAGE_W-1:0] page_number_o;
  logic [MAP_W-1:0]  block_mask_o;
  logic              entry_valid_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              ignore_reuse_i;

  footprint_model    model = new();
  logic [PAGE_W-1:0] page_pool [POOL];
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                hold_req = 0;
  int                cycles = 0;

  page_footprint_recorder_unit #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .page_number_o (page_number_o),
    .block_mask_o  (block_mask_o),
    .entry_valid_o (entry_valid_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .ignore_reuse_i(ignore_reuse_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.check_word(page_number_o, block_mask_o, entry_valid_o, last_o);
    end
  end

  // The receiver normally stalls at random; a hold-off request keeps it
  // stalled for as long as hold_req asks so the block backs up.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    address_i  <= addr;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    model.note_item(mode, addr);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (model.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic value);
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    ignore_reuse_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    model.ignore_reuse = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [ADDR_W-1:0] a;
    int                pick;
    a    = rand_addr();
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_item(MODE_RECORD, {page_pool[$urandom_range(POOL - 1)], a[PAGE_LSB-1:0]});
    end else if (pick < 60) begin
      send_item(MODE_REUSE, {page_pool[$urandom_range(POOL - 1)], a[PAGE_LSB-1:0]});
    end else if (pick < 75) begin
      send_item(MODE_GATHER, a);
    end else if (pick < 80) begin
      send_item(MODE_UNUSED, a);
    end else if (pick < 92) begin
      send_item(MODE_RECORD, a);
    end else begin
      send_item(MODE_REUSE, a);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] hot;
    logic [ADDR_W-1:0] a;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_RECORD;
    address_i      = '0;
    cfg_valid_i    = 1'b0;
    ignore_reuse_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(1'b0);

    // Empty table, both page extremes, a hit, reuse marks, the unused mode,
    // then a full table and one eviction.
    send_item(MODE_GATHER, '1);
    send_item(MODE_RECORD, '0);
    send_item(MODE_RECORD, '1);
    send_item(MODE_RECORD, 64'h0000_0000_0000_0FC0);
    send_item(MODE_REUSE, '1);
    send_item(MODE_REUSE, rand_addr());
    send_item(MODE_UNUSED, '1);
    send_item(MODE_GATHER, '0);
    hot = '0;
    for (int n = 0; n < ENTRIES - 1; n++) begin
      hot = rand_addr();
      send_item(MODE_RECORD, hot);
    end
    send_item(MODE_GATHER, rand_addr());

    // Hit one page repeatedly so the other entries grow older.
    quiesce();
    write_cfg(1'b1);
    for (int n = 0; n < HOT_HITS; n++) begin
      a = rand_addr();
      send_item(MODE_RECORD, {hot[ADDR_W-1:PAGE_LSB], a[PAGE_LSB-1:0]});
    end
    send_item(MODE_GATHER, '0);
    send_item(MODE_RECORD, rand_addr());
    send_item(MODE_RECORD, rand_addr());
    send_item(MODE_GATHER, '0);

    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      write_cfg(1'(ph % 2));
      send_idle_pct = (ph == 1) ? 58 : (ph == 3) ? 32 : 0;
      stall_pct     = (ph == 2) ? 58 : (ph == 3) ? 32 : 0;
      for (int i = 0; i < POOL; i++) begin
        a            = rand_addr();
        page_pool[i] = a[PAGE_W-1:0];
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) begin
          hold_req = 300;
          send_item(MODE_GATHER, rand_addr());
        end
        if (ph == 2 && n == 25) begin
          quiesce();
        end
        send_random_item();
      end
    end
    quiesce();

    if (model.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
